@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define WPI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define WPI_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define WPI_ASSERT(lbl, clk, rstn, prop, msg)
`define WPI_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ rtl/core/wpi_pkg.sv @@
// ----------------------------------------------------------------------------
// wpi_pkg
// shared types and constants of the waypoint path interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package wpi_pkg;

    localparam int COORD_W   = 32;
    localparam int QUAT_W    = 16;
    localparam int STEP_W    = 31;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int ARITH_W   = 66;
    localparam int CNT_W     = 6;
    localparam int ITER_W    = 7;
    localparam int MAX_STEPS = 62;
    localparam int CFG_IDX_W = 1;

    localparam logic signed [QUAT_W-1:0] Q14_ONE = 16'sd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DISTANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_OFF   = 1'b1;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic done;
    } arith_rsp_t;

    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] p,
        input logic signed [DIFF_W-1:0]  inc
    );
        logic signed [COORD_W+1:0] s;
        s = {{2{p[COORD_W-1]}}, p} + {inc[DIFF_W-1], inc};
        if (s[COORD_W+1:COORD_W-1] == 3'b000 || s[COORD_W+1:COORD_W-1] == 3'b111)
        begin
            return s[COORD_W-1:0];
        end
        else if (s[COORD_W+1])
        begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/wpi_if.sv @@
// ----------------------------------------------------------------------------
// wpi channel interfaces
// valid/ready channels for waypoints, emitted points and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface wpi_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wpi_pkg::COORD_W-1:0]   pos_x;
    logic signed [wpi_pkg::COORD_W-1:0]   pos_y;
    logic signed [wpi_pkg::QUAT_W-1:0]    quat_z;
    logic signed [wpi_pkg::QUAT_W-1:0]    quat_w;
    logic                                 first_point;
    logic                                 last_point;

    modport source (output valid, pos_x, pos_y, quat_z, quat_w, first_point, last_point,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, quat_z, quat_w, first_point, last_point,
                    output ready);
endinterface

interface wpi_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wpi_pkg::COORD_W-1:0]   out_x;
    logic signed [wpi_pkg::COORD_W-1:0]   out_y;
    logic signed [wpi_pkg::QUAT_W-1:0]    out_quat_z;
    logic signed [wpi_pkg::QUAT_W-1:0]    out_quat_w;
    logic                                 is_interpolated;
    logic                                 last_of_run;
    logic                                 path_end;

    modport source (output valid, out_x, out_y, out_quat_z, out_quat_w, is_interpolated,
                    last_of_run, path_end, input ready);
    modport sink   (input valid, out_x, out_y, out_quat_z, out_quat_w, is_interpolated,
                    last_of_run, path_end, output ready);
endinterface

interface wpi_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [wpi_pkg::CFG_IDX_W-1:0]        index;
    logic [wpi_pkg::STEP_W-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wpi_arith_unit.sv @@
// ----------------------------------------------------------------------------
// wpi_arith_unit
// bit-serial shared unit: shift-add multiply, restoring divide, square root
// ----------------------------------------------------------------------------
`default_nettype none

module wpi_arith_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wpi_pkg::arith_req_t           req,
    input  wire logic [wpi_pkg::ARITH_W-1:0]   opa,
    input  wire logic [wpi_pkg::ARITH_W-1:0]   opb,
    output wpi_pkg::arith_rsp_t                rsp,
    output logic [wpi_pkg::ARITH_W-1:0]        result
);

    localparam int W = wpi_pkg::ARITH_W;

    logic                          busy_reg;
    logic                          done_reg;
    wpi_pkg::arith_op_t            op_reg;
    logic [wpi_pkg::ITER_W-1:0]    cnt_reg;
    logic [W-1:0]                  src_reg;
    logic [W-1:0]                  aux_reg;
    logic [W-1:0]                  acc_reg;
    logic [W-1:0]                  rem_reg;

    logic [W-1:0]                  mul_sum;
    logic [W-1:0]                  cmp_lhs;
    logic [W-1:0]                  cmp_rhs;
    logic [W:0]                    diff;
    logic                          ge;

    always_comb
    begin
        mul_sum = acc_reg + aux_reg;
        if (op_reg == wpi_pkg::OP_SQRT)
        begin
            cmp_lhs = {rem_reg[W-3:0], src_reg[W-1:W-2]};
            cmp_rhs = {acc_reg[W-3:0], 2'b01};
        end
        else
        begin
            cmp_lhs = {rem_reg[W-2:0], src_reg[W-3]};
            cmp_rhs = aux_reg;
        end
        diff = {1'b0, cmp_lhs} - {1'b0, cmp_rhs};
        ge   = !diff[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= wpi_pkg::OP_MUL;
            cnt_reg  <= '0;
            src_reg  <= '0;
            aux_reg  <= '0;
            acc_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                acc_reg  <= '0;
                rem_reg  <= '0;
                aux_reg  <= opb;
                unique case (req.op)
                    wpi_pkg::OP_MUL:
                    begin
                        src_reg <= opa;
                        cnt_reg <= wpi_pkg::ITER_W'(33);
                    end
                    wpi_pkg::OP_DIV:
                    begin
                        src_reg <= opa;
                        cnt_reg <= wpi_pkg::ITER_W'(64);
                    end
                    wpi_pkg::OP_SQRT:
                    begin
                        src_reg <= opa;
                        cnt_reg <= wpi_pkg::ITER_W'(33);
                    end
                    default:
                    begin
                        src_reg <= opa;
                        cnt_reg <= wpi_pkg::ITER_W'(1);
                    end
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == wpi_pkg::ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                unique case (op_reg)
                    wpi_pkg::OP_MUL:
                    begin
                        if (src_reg[0])
                        begin
                            acc_reg <= mul_sum;
                        end
                        src_reg <= {1'b0, src_reg[W-1:1]};
                        aux_reg <= {aux_reg[W-2:0], 1'b0};
                    end
                    wpi_pkg::OP_DIV:
                    begin
                        rem_reg <= ge ? diff[W-1:0] : cmp_lhs;
                        acc_reg <= {acc_reg[W-2:0], ge};
                        src_reg <= {src_reg[W-2:0], 1'b0};
                    end
                    wpi_pkg::OP_SQRT:
                    begin
                        rem_reg <= ge ? diff[W-1:0] : cmp_lhs;
                        acc_reg <= {acc_reg[W-2:0], ge};
                        src_reg <= {src_reg[W-3:0], 2'b00};
                    end
                    default:
                    begin
                        acc_reg <= acc_reg;
                    end
                endcase
            end
        end
    end

    assign rsp.done = done_reg;
    assign result   = acc_reg;

endmodule

`default_nettype wire

@@ rtl/core/waypoint_path_interpolator.sv @@
// ----------------------------------------------------------------------------
// waypoint_path_interpolator
// linear interpolation of points between successive waypoints
// ----------------------------------------------------------------------------
// usage
// waypoint: valid/ready channel of waypoints (x, y, quaternion, first/last).
// point: valid/ready channel of emitted points, held in an output register.
// cfg: register write channel, always ready; write only while idle.
// a waypoint that starts a path (or arrives with none held) is stored at
// once; a lone goal is emitted in the next cycle.
// a following waypoint runs a segment job on one bit-serial unit: squares,
// square root, count divide, multiply and divide per axis, and with heading
// on a divide and root each for w and z (a zero-length segment stops at the
// root), then emits one point per cycle while the receiver takes them.
// the next waypoint is taken only after the last item of the run has been
// loaded into the output register; a stalled receiver holds the sequencer.
// reset clears the held waypoint and loads step 1.0 m with heading off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module waypoint_path_interpolator
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    wpi_in_if.sink     waypoint,
    wpi_out_if.source  point,
    wpi_cfg_if.sink    cfg
);

    localparam int CW = wpi_pkg::COORD_W;
    localparam int QW = wpi_pkg::QUAT_W;
    localparam int DW = wpi_pkg::DIFF_W;
    localparam int AW = wpi_pkg::ARITH_W;
    localparam int NW = CW + 3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_CNT,
        S_MULX,
        S_DIVX,
        S_MULY,
        S_DIVY,
        S_HWDIV,
        S_HWSQ,
        S_HZDIV,
        S_HZSQ,
        S_EMIT_PREV,
        S_EMIT_PTS,
        S_EMIT_GOAL
    } state_t;

    state_t                           state_reg;
    logic                             issue_reg;

    logic [wpi_pkg::STEP_W-1:0]       step_reg;
    logic                             heading_off_reg;

    logic signed [CW-1:0]             prev_x_reg;
    logic signed [CW-1:0]             prev_y_reg;
    logic signed [QW-1:0]             prev_qz_reg;
    logic signed [QW-1:0]             prev_qw_reg;
    logic                             have_prev_reg;

    logic signed [CW-1:0]             cur_x_reg;
    logic signed [CW-1:0]             cur_y_reg;
    logic signed [QW-1:0]             cur_qz_reg;
    logic signed [QW-1:0]             cur_qw_reg;
    logic                             cur_last_reg;

    logic signed [DW-1:0]             dx_reg;
    logic signed [DW-1:0]             dy_reg;
    logic [AW-1:0]                    acc_reg;
    logic [DW-1:0]                    dist_reg;
    logic [wpi_pkg::CNT_W-1:0]        cnt_reg;
    logic [wpi_pkg::CNT_W-1:0]        k_reg;
    logic signed [DW-1:0]             ix_reg;
    logic signed [DW-1:0]             iy_reg;
    logic signed [QW-1:0]             hz_reg;
    logic signed [QW-1:0]             hw_reg;
    logic signed [CW-1:0]             px_reg;
    logic signed [CW-1:0]             py_reg;

    logic                             out_valid_reg;
    logic signed [CW-1:0]             out_x_reg;
    logic signed [CW-1:0]             out_y_reg;
    logic signed [QW-1:0]             out_qz_reg;
    logic signed [QW-1:0]             out_qw_reg;
    logic                             out_interp_reg;
    logic                             out_lor_reg;
    logic                             out_pend_reg;

    wpi_pkg::arith_req_t              arith_req;
    wpi_pkg::arith_rsp_t              arith_rsp;
    logic [AW-1:0]                    opa;
    logic [AW-1:0]                    opb;
    logic [AW-1:0]                    result;

    logic                             out_free;
    logic                             in_fire;
    logic                             in_job;
    logic [DW-1:0]                    ax;
    logic [DW-1:0]                    ay;
    logic [wpi_pkg::STEP_W-1:0]       step_eff;
    logic [NW-1:0]                    hw_num;
    logic [NW-1:0]                    hz_num;
    logic [QW:0]                      half_rnd;
    logic [DW-1:0]                    inc_mag;
    logic [wpi_pkg::CNT_W-1:0]        k_inc;
    logic signed [CW-1:0]             px_sat;
    logic signed [CW-1:0]             py_sat;

    always_comb
    begin
        out_free = !out_valid_reg || point.ready;
        in_fire  = waypoint.valid && waypoint.ready;
        in_job   = (state_reg != S_IDLE) && (state_reg != S_EMIT_PREV)
                   && (state_reg != S_EMIT_PTS) && (state_reg != S_EMIT_GOAL);
        ax       = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        ay       = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        step_eff = (step_reg == '0) ? wpi_pkg::STEP_W'(1) : step_reg;
        hw_num   = {2'b00, dist_reg} + {{2{dx_reg[DW-1]}}, dx_reg};
        hz_num   = {2'b00, dist_reg} - {{2{dx_reg[DW-1]}}, dx_reg};
        half_rnd = {1'b0, result[QW-1:0]} + 1'b1;
        inc_mag  = result[DW-1:0];
        k_inc    = k_reg + 1'b1;
        px_sat   = wpi_pkg::sat_add(px_reg, ix_reg);
        py_sat   = wpi_pkg::sat_add(py_reg, iy_reg);
    end

    always_comb
    begin
        arith_req.start = issue_reg;
        arith_req.op    = wpi_pkg::OP_MUL;
        opa             = '0;
        opb             = '0;
        unique case (state_reg)
            S_SQX:
            begin
                opa = AW'(ax);
                opb = AW'(ax);
            end
            S_SQY:
            begin
                opa = AW'(ay);
                opb = AW'(ay);
            end
            S_ROOT:
            begin
                arith_req.op = wpi_pkg::OP_SQRT;
                opa          = acc_reg;
            end
            S_CNT:
            begin
                arith_req.op = wpi_pkg::OP_DIV;
                opa          = AW'(dist_reg);
                opb          = AW'(step_eff);
            end
            S_MULX:
            begin
                opa = AW'(ax);
                opb = AW'(step_eff);
            end
            S_MULY:
            begin
                opa = AW'(ay);
                opb = AW'(step_eff);
            end
            S_DIVX, S_DIVY:
            begin
                arith_req.op = wpi_pkg::OP_DIV;
                opa          = acc_reg + AW'(dist_reg[DW-1:1]);
                opb          = AW'(dist_reg);
            end
            S_HWDIV:
            begin
                arith_req.op = wpi_pkg::OP_DIV;
                opa          = {{(AW-NW-27){1'b0}}, hw_num, 27'd0};
                opb          = AW'(dist_reg);
            end
            S_HZDIV:
            begin
                arith_req.op = wpi_pkg::OP_DIV;
                opa          = {{(AW-NW-27){1'b0}}, hz_num, 27'd0};
                opb          = AW'(dist_reg);
            end
            S_HWSQ, S_HZSQ:
            begin
                arith_req.op = wpi_pkg::OP_SQRT;
                opa          = {acc_reg[AW-3:0], 2'b00};
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    wpi_arith_unit u_arith
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (arith_req),
        .opa    (opa),
        .opb    (opb),
        .rsp    (arith_rsp),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            issue_reg       <= 1'b0;
            step_reg        <= wpi_pkg::STEP_W'(65536);
            heading_off_reg <= 1'b1;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_qz_reg     <= '0;
            prev_qw_reg     <= '0;
            have_prev_reg   <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            cur_qz_reg      <= '0;
            cur_qw_reg      <= '0;
            cur_last_reg    <= 1'b0;
            dx_reg          <= '0;
            dy_reg          <= '0;
            acc_reg         <= '0;
            dist_reg        <= '0;
            cnt_reg         <= '0;
            k_reg           <= '0;
            ix_reg          <= '0;
            iy_reg          <= '0;
            hz_reg          <= '0;
            hw_reg          <= wpi_pkg::Q14_ONE;
            px_reg          <= '0;
            py_reg          <= '0;
            out_valid_reg   <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_qz_reg      <= '0;
            out_qw_reg      <= '0;
            out_interp_reg  <= 1'b0;
            out_lor_reg     <= 1'b0;
            out_pend_reg    <= 1'b0;
        end
        else
        begin
            issue_reg <= 1'b0;
            if (point.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                if (cfg.index == wpi_pkg::CFG_STEP_DISTANCE)
                begin
                    step_reg <= cfg.data;
                end
                else
                begin
                    heading_off_reg <= cfg.data[0];
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (waypoint.first_point || !have_prev_reg)
                        begin
                            if (waypoint.last_point)
                            begin
                                out_valid_reg  <= 1'b1;
                                out_x_reg      <= waypoint.pos_x;
                                out_y_reg      <= waypoint.pos_y;
                                out_qz_reg     <= waypoint.quat_z;
                                out_qw_reg     <= waypoint.quat_w;
                                out_interp_reg <= 1'b0;
                                out_lor_reg    <= 1'b1;
                                out_pend_reg   <= 1'b1;
                                have_prev_reg  <= 1'b0;
                            end
                            else
                            begin
                                prev_x_reg    <= waypoint.pos_x;
                                prev_y_reg    <= waypoint.pos_y;
                                prev_qz_reg   <= waypoint.quat_z;
                                prev_qw_reg   <= waypoint.quat_w;
                                have_prev_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            cur_x_reg    <= waypoint.pos_x;
                            cur_y_reg    <= waypoint.pos_y;
                            cur_qz_reg   <= waypoint.quat_z;
                            cur_qw_reg   <= waypoint.quat_w;
                            cur_last_reg <= waypoint.last_point;
                            dx_reg       <= {waypoint.pos_x[CW-1], waypoint.pos_x}
                                            - {prev_x_reg[CW-1], prev_x_reg};
                            dy_reg       <= {waypoint.pos_y[CW-1], waypoint.pos_y}
                                            - {prev_y_reg[CW-1], prev_y_reg};
                            px_reg       <= prev_x_reg;
                            py_reg       <= prev_y_reg;
                            state_reg    <= S_SQX;
                            issue_reg    <= 1'b1;
                        end
                    end
                end
                S_SQX:
                begin
                    if (arith_rsp.done)
                    begin
                        acc_reg   <= result;
                        state_reg <= S_SQY;
                        issue_reg <= 1'b1;
                    end
                end
                S_SQY:
                begin
                    if (arith_rsp.done)
                    begin
                        acc_reg   <= acc_reg + result;
                        state_reg <= S_ROOT;
                        issue_reg <= 1'b1;
                    end
                end
                S_ROOT:
                begin
                    if (arith_rsp.done)
                    begin
                        dist_reg <= result[DW-1:0];
                        if (result[DW-1:0] == '0)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_EMIT_PREV;
                        end
                        else
                        begin
                            state_reg <= S_CNT;
                            issue_reg <= 1'b1;
                        end
                    end
                end
                S_CNT:
                begin
                    if (arith_rsp.done)
                    begin
                        if (result[AW-1:wpi_pkg::CNT_W] != '0
                            || result[wpi_pkg::CNT_W-1:0] > wpi_pkg::CNT_W'(wpi_pkg::MAX_STEPS))
                        begin
                            cnt_reg <= wpi_pkg::CNT_W'(wpi_pkg::MAX_STEPS);
                        end
                        else
                        begin
                            cnt_reg <= result[wpi_pkg::CNT_W-1:0];
                        end
                        state_reg <= S_MULX;
                        issue_reg <= 1'b1;
                    end
                end
                S_MULX:
                begin
                    if (arith_rsp.done)
                    begin
                        acc_reg   <= result;
                        state_reg <= S_DIVX;
                        issue_reg <= 1'b1;
                    end
                end
                S_DIVX:
                begin
                    if (arith_rsp.done)
                    begin
                        ix_reg    <= dx_reg[DW-1] ? -$signed(inc_mag) : $signed(inc_mag);
                        state_reg <= S_MULY;
                        issue_reg <= 1'b1;
                    end
                end
                S_MULY:
                begin
                    if (arith_rsp.done)
                    begin
                        acc_reg   <= result;
                        state_reg <= S_DIVY;
                        issue_reg <= 1'b1;
                    end
                end
                S_DIVY:
                begin
                    if (arith_rsp.done)
                    begin
                        iy_reg <= dy_reg[DW-1] ? -$signed(inc_mag) : $signed(inc_mag);
                        if (heading_off_reg)
                        begin
                            hz_reg    <= '0;
                            hw_reg    <= wpi_pkg::Q14_ONE;
                            state_reg <= S_EMIT_PREV;
                        end
                        else
                        begin
                            state_reg <= S_HWDIV;
                            issue_reg <= 1'b1;
                        end
                    end
                end
                S_HWDIV:
                begin
                    if (arith_rsp.done)
                    begin
                        acc_reg   <= result;
                        state_reg <= S_HWSQ;
                        issue_reg <= 1'b1;
                    end
                end
                S_HWSQ:
                begin
                    if (arith_rsp.done)
                    begin
                        hw_reg    <= half_rnd[QW:1];
                        state_reg <= S_HZDIV;
                        issue_reg <= 1'b1;
                    end
                end
                S_HZDIV:
                begin
                    if (arith_rsp.done)
                    begin
                        acc_reg   <= result;
                        state_reg <= S_HZSQ;
                        issue_reg <= 1'b1;
                    end
                end
                S_HZSQ:
                begin
                    if (arith_rsp.done)
                    begin
                        hz_reg    <= dy_reg[DW-1] ? -$signed(half_rnd[QW:1])
                                                  : $signed(half_rnd[QW:1]);
                        state_reg <= S_EMIT_PREV;
                    end
                end
                S_EMIT_PREV:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_x_reg      <= prev_x_reg;
                        out_y_reg      <= prev_y_reg;
                        out_qz_reg     <= prev_qz_reg;
                        out_qw_reg     <= prev_qw_reg;
                        out_interp_reg <= 1'b0;
                        out_lor_reg    <= (cnt_reg == '0) && !cur_last_reg;
                        out_pend_reg   <= 1'b0;
                        k_reg          <= '0;
                        if (cnt_reg != '0)
                        begin
                            state_reg <= S_EMIT_PTS;
                        end
                        else if (cur_last_reg)
                        begin
                            state_reg <= S_EMIT_GOAL;
                        end
                        else
                        begin
                            prev_x_reg    <= cur_x_reg;
                            prev_y_reg    <= cur_y_reg;
                            prev_qz_reg   <= cur_qz_reg;
                            prev_qw_reg   <= cur_qw_reg;
                            have_prev_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_EMIT_PTS:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_x_reg      <= px_sat;
                        out_y_reg      <= py_sat;
                        out_qz_reg     <= hz_reg;
                        out_qw_reg     <= hw_reg;
                        out_interp_reg <= 1'b1;
                        out_lor_reg    <= (k_inc == cnt_reg) && !cur_last_reg;
                        out_pend_reg   <= 1'b0;
                        px_reg         <= px_sat;
                        py_reg         <= py_sat;
                        k_reg          <= k_inc;
                        if (k_inc == cnt_reg)
                        begin
                            if (cur_last_reg)
                            begin
                                state_reg <= S_EMIT_GOAL;
                            end
                            else
                            begin
                                prev_x_reg    <= cur_x_reg;
                                prev_y_reg    <= cur_y_reg;
                                prev_qz_reg   <= cur_qz_reg;
                                prev_qw_reg   <= cur_qw_reg;
                                have_prev_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                        end
                    end
                end
                S_EMIT_GOAL:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_x_reg      <= cur_x_reg;
                        out_y_reg      <= cur_y_reg;
                        out_qz_reg     <= cur_qz_reg;
                        out_qw_reg     <= cur_qw_reg;
                        out_interp_reg <= 1'b0;
                        out_lor_reg    <= 1'b1;
                        out_pend_reg   <= 1'b1;
                        have_prev_reg  <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign waypoint.ready        = (state_reg == S_IDLE) && out_free;
    assign cfg.ready             = 1'b1;
    assign point.valid           = out_valid_reg;
    assign point.out_x           = out_x_reg;
    assign point.out_y           = out_y_reg;
    assign point.out_quat_z      = out_qz_reg;
    assign point.out_quat_w      = out_qw_reg;
    assign point.is_interpolated = out_interp_reg;
    assign point.last_of_run     = out_lor_reg;
    assign point.path_end        = out_pend_reg;

    `WPI_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= wpi_pkg::CNT_W'(wpi_pkg::MAX_STEPS), "point count above limit")
    `WPI_ASSERT(a_k_below_cnt, clk, rst_n, state_reg == S_EMIT_PTS |-> k_reg < cnt_reg, "point index overran count")
    `WPI_ASSERT(a_done_in_job, clk, rst_n, arith_rsp.done |-> in_job, "unit result outside a job")
    `WPI_ASSERT_NEVER(a_goal_keeps_prev, clk, rst_n, $rose(point.valid) && point.path_end && have_prev_reg, "goal with waypoint held")

endmodule

`default_nettype wire
